// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== src/ehfc_pkg.sv =====
`default_nettype none

package ehfc_pkg;

   // Build defaults
   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int MID_DEPTH_DEFAULT   = 4;
   localparam int RSP_DEPTH_DEFAULT   = 2;

   // Timeout register
   localparam int                TIMEOUT_BITS  = 24;
   localparam logic [23:0]       TIMEOUT_RESET = 24'd60000;

   // Byte offsets inside the 802.11 frame
   localparam int POS_FRAME_CTRL  = 0;
   localparam int POS_ADDR2_FIRST = 10;
   localparam int POS_ADDR2_LAST  = 15;
   localparam int POS_SNAP_DSAP   = 24;
   localparam int POS_SNAP_SSAP   = 25;
   localparam int POS_SNAP_CTRL   = 26;
   localparam int POS_ETYPE_HI    = 30;
   localparam int POS_ETYPE_LO    = 31;
   localparam int POS_KEY_INFO_HI = 37;
   localparam int POS_KEY_INFO_LO = 38;

   // Expected header values
   localparam logic [7:0] FC_TYPE_MASK = 8'h0C;
   localparam logic [7:0] FC_TYPE_DATA = 8'h08;
   localparam logic [7:0] SNAP_SAP     = 8'hAA;
   localparam logic [7:0] SNAP_UI      = 8'h03;
   localparam logic [7:0] ETYPE_HI     = 8'h88;
   localparam logic [7:0] ETYPE_LO     = 8'h8E;

   // Key-info bits
   localparam logic [7:0] KI_ACK    = 8'h80;
   localparam logic [7:0] KI_MIC    = 8'h01;
   localparam logic [7:0] KI_SECURE = 8'h02;

   // Message numbers
   localparam logic [2:0] MSG_NONE = 3'd0;
   localparam logic [2:0] MSG_1    = 3'd1;
   localparam logic [2:0] MSG_2    = 3'd2;
   localparam logic [2:0] MSG_3    = 3'd3;
   localparam logic [2:0] MSG_4    = 3'd4;

   // Result kinds
   localparam logic EVENT_VERDICT = 1'b0;
   localparam logic EVENT_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      CMD_FRAME_BYTE = 2'd0,
      CMD_TICK       = 2'd1,
      CMD_START      = 2'd2,
      CMD_RESTART    = 2'd3
   } ehfc_cmd_type;

   typedef struct packed {
      ehfc_cmd_type command;
      logic [7:0]   frame_byte;
      logic         last_byte;
   } ehfc_req_type;

   typedef struct packed {
      logic        event_kind;
      logic [2:0]  message_number;
      logic [3:0]  seen_mask;
      logic        complete;
      logic        active;
      logic [47:0] peer_address;
      logic [15:0] frame_length;
   } ehfc_rsp_type;

   // Entry handed from the parser to the capture tracker
   typedef struct packed {
      ehfc_cmd_type op;
      logic         qualify;
      logic [2:0]   message;
      logic [47:0]  address;
      logic [15:0]  length;
   } ehfc_mid_type;

   // Key message number from the two key-info bytes
   function automatic logic [2:0] ehfc_classify(input logic [7:0] hi, input logic [7:0] lo);
      logic ack;
      logic mic;
      logic sec;
      ack = (lo & KI_ACK) != 8'h00;
      mic = (hi & KI_MIC) != 8'h00;
      sec = (hi & KI_SECURE) != 8'h00;
      if (ack) begin
         return (mic && sec) ? MSG_3 : MSG_1;
      end
      return sec ? MSG_4 : MSG_2;
   endfunction

endpackage

`default_nettype wire

// ===== src/eapol_handshake_frame_classifier.sv =====
`default_nettype none

// EAPOL key handshake classifier. Frame bytes, millisecond ticks, start and
// restart commands enter on the req_ queue, one beat per cycle while req_full is
// low; the parser tracks header checks and key-info per byte and queues a compact
// entry at each frame end or command. The capture tracker retires one entry per
// cycle while the result queue has room, so the sustained rate is one beat per
// cycle while rsp_ is drained; a verdict passes through the entry queue and then
// the result queue before it appears on rsp_. A timeout beat comes from the tick
// that pushes elapsed time past the limit. The limit register must be written on
// csr_ only while the block is idle, which the block does not enforce; it resets to 60000.
module eapol_handshake_frame_classifier
   import ehfc_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
   parameter int MID_DEPTH   = MID_DEPTH_DEFAULT,
   parameter int RSP_DEPTH   = RSP_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output      logic                    req_full,
   input  wire ehfc_req_type            req_beat,
   output      logic                    rsp_empty,
   input  wire logic                    rsp_pop,
   output      ehfc_rsp_type            rsp_beat,
   input  wire logic                    csr_write_enable,
   input  wire logic [TIMEOUT_BITS-1:0] csr_write_data
);

   localparam int MID_W = $bits(ehfc_mid_type);
   localparam int RSP_W = $bits(ehfc_rsp_type);

   logic         mid_push;
   ehfc_mid_type mid_in_entry;
   ehfc_mid_type mid_out_entry;
   logic         mid_full;
   logic         mid_empty;
   logic         mid_pop;
   logic         rsp_full;
   logic         rsp_push;
   ehfc_rsp_type rsp_in_beat;

   assign req_full = mid_full;

   ehfc_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_push && !req_full),
      .beat      (req_beat),
      .mid_push  (mid_push),
      .mid_entry (mid_in_entry)
   );

   ehfc_fifo #(
      .WIDTH(MID_W),
      .DEPTH(MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_entry),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_entry),
      .empty     (mid_empty)
   );

   ehfc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mid_empty        (mid_empty),
      .mid_entry        (mid_out_entry),
      .mid_pop          (mid_pop),
      .rsp_full         (rsp_full),
      .rsp_push         (rsp_push),
      .rsp_beat         (rsp_in_beat)
   );

   ehfc_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in_beat),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_beat),
      .empty     (rsp_empty)
   );

endmodule

`default_nettype wire

// ===== src/ehfc_fifo.sv =====
`default_nettype none

`include "assert_macros.svh"

module ehfc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] pop_data,
   output      logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = count_ff == CW'(DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "fifo count over depth")
   `ASSERT_NEXT(a_pop_drains, clock, reset, do_pop && !do_push, count_ff == CW'($past(count_ff) - 1'b1), "pop did not drain")
   `ASSERT_NEXT(a_push_fills, clock, reset, do_push && !do_pop, !empty, "push left fifo empty")

endmodule

`default_nettype wire

// ===== src/ehfc_front.sv =====
`default_nettype none

module ehfc_front
   import ehfc_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire ehfc_req_type beat,
   output      logic         mid_push,
   output      ehfc_mid_type mid_entry
);

   localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

   logic [LENGTH_BITS-1:0] pos_ff, pos_in;
   logic                   hdr_ok_ff, hdr_ok_in;
   logic [7:0]             key_hi_ff, key_hi_in;
   logic [7:0]             key_lo_ff, key_lo_in;
   logic [47:0]            addr_ff, addr_in;
   logic [LENGTH_BITS-1:0] len;
   logic                   hdr_now;

   // per-byte header checks and field capture
   always_comb begin
      pos_in    = pos_ff;
      hdr_ok_in = hdr_ok_ff;
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      addr_in   = addr_ff;
      hdr_now   = hdr_ok_ff;
      len       = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 1'b1;
      mid_push  = 1'b0;
      mid_entry = '{op: beat.command, qualify: 1'b0, message: MSG_NONE,
                    address: addr_ff, length: 16'd0};
      if (accept) begin
         case (beat.command)
            CMD_FRAME_BYTE: begin
               if (pos_ff == LENGTH_BITS'(POS_FRAME_CTRL) &&
                   (beat.frame_byte & FC_TYPE_MASK) != FC_TYPE_DATA) begin
                  hdr_now = 1'b0;
               end
               if ((pos_ff == LENGTH_BITS'(POS_SNAP_DSAP) ||
                    pos_ff == LENGTH_BITS'(POS_SNAP_SSAP)) && beat.frame_byte != SNAP_SAP) begin
                  hdr_now = 1'b0;
               end
               if (pos_ff == LENGTH_BITS'(POS_SNAP_CTRL) && beat.frame_byte != SNAP_UI) begin
                  hdr_now = 1'b0;
               end
               if (pos_ff == LENGTH_BITS'(POS_ETYPE_HI) && beat.frame_byte != ETYPE_HI) begin
                  hdr_now = 1'b0;
               end
               if (pos_ff == LENGTH_BITS'(POS_ETYPE_LO) && beat.frame_byte != ETYPE_LO) begin
                  hdr_now = 1'b0;
               end
               if (pos_ff == LENGTH_BITS'(POS_KEY_INFO_HI)) begin
                  key_hi_in = beat.frame_byte;
               end
               if (pos_ff == LENGTH_BITS'(POS_KEY_INFO_LO)) begin
                  key_lo_in = beat.frame_byte;
               end
               if (pos_ff >= LENGTH_BITS'(POS_ADDR2_FIRST) &&
                   pos_ff <= LENGTH_BITS'(POS_ADDR2_LAST)) begin
                  addr_in = {addr_ff[39:0], beat.frame_byte};
               end
               // frame end: hand the verdict inputs to the back
               if (beat.last_byte) begin
                  mid_push          = 1'b1;
                  mid_entry.qualify = hdr_now && pos_ff >= LENGTH_BITS'(POS_KEY_INFO_LO);
                  mid_entry.message = ehfc_classify(key_hi_in, key_lo_in);
                  mid_entry.address = addr_in;
                  mid_entry.length  = 16'(len);
                  pos_in            = '0;
                  hdr_ok_in         = 1'b1;
               end else begin
                  pos_in    = len;
                  hdr_ok_in = hdr_now;
               end
            end
            CMD_START: begin
               // abandon any partial frame
               mid_push  = 1'b1;
               pos_in    = '0;
               hdr_ok_in = 1'b1;
            end
            default: begin
               mid_push = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hdr_ok_ff <= 1'b1;
         key_hi_ff <= '0;
         key_lo_ff <= '0;
         addr_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         hdr_ok_ff <= hdr_ok_in;
         key_hi_ff <= key_hi_in;
         key_lo_ff <= key_lo_in;
         addr_ff   <= addr_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ehfc_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module ehfc_back
   import ehfc_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write_enable,
   input  wire logic [TIMEOUT_BITS-1:0] csr_write_data,
   input  wire logic                    mid_empty,
   input  wire ehfc_mid_type            mid_entry,
   output      logic                    mid_pop,
   input  wire logic                    rsp_full,
   output      logic                    rsp_push,
   output      ehfc_rsp_type            rsp_beat
);

   logic [TIMEOUT_BITS-1:0] limit_ff, limit_in;
   logic [3:0]              seen_ff, seen_in;
   logic                    done_ff, done_in;
   logic                    running_ff, running_in;
   logic [TIMEOUT_BITS-1:0] elapsed_ff, elapsed_in;
   logic [47:0]             stored_ff, stored_in;
   logic                    go;
   logic [TIMEOUT_BITS:0]   elapsed_inc;
   logic [2:0]              msg;
   logic                    kind;
   logic [15:0]             len;
   logic [3:0]              seen_new;

   assign go          = !mid_empty && !rsp_full;
   assign mid_pop     = go;
   assign elapsed_inc = {1'b0, elapsed_ff} + 1'b1;

   // capture state update, one queue entry per cycle while the result queue has room
   always_comb begin
      limit_in   = csr_write_enable ? csr_write_data : limit_ff;
      seen_in    = seen_ff;
      done_in    = done_ff;
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      stored_in  = stored_ff;
      rsp_push   = 1'b0;
      msg        = MSG_NONE;
      kind       = EVENT_VERDICT;
      len        = 16'd0;
      seen_new   = seen_ff | (4'b0001 << (mid_entry.message - 1'b1));
      if (go) begin
         case (mid_entry.op)
            CMD_TICK: begin
               if (running_ff && !done_ff) begin
                  elapsed_in = elapsed_inc[TIMEOUT_BITS] ? '1 : elapsed_inc[TIMEOUT_BITS-1:0];
                  if (elapsed_inc > {1'b0, limit_ff}) begin
                     running_in = 1'b0;
                     rsp_push   = 1'b1;
                     kind       = EVENT_TIMEOUT;
                  end
               end
            end
            CMD_START: begin
               seen_in    = '0;
               done_in    = 1'b0;
               elapsed_in = '0;
               running_in = 1'b1;
            end
            CMD_RESTART: begin
               if (done_ff) begin
                  seen_in    = '0;
                  done_in    = 1'b0;
                  elapsed_in = '0;
               end
            end
            default: begin
               // frame verdict
               rsp_push = 1'b1;
               len      = mid_entry.length;
               if (running_ff && !done_ff && mid_entry.qualify) begin
                  msg       = mid_entry.message;
                  seen_in   = seen_new;
                  stored_in = mid_entry.address;
                  done_in   = seen_new == 4'hF;
               end
            end
         endcase
      end
   end

   // result shows the state after this beat
   always_comb begin
      rsp_beat.event_kind     = kind;
      rsp_beat.message_number = msg;
      rsp_beat.seen_mask      = seen_in;
      rsp_beat.complete       = done_in;
      rsp_beat.active         = running_in;
      rsp_beat.peer_address   = stored_in;
      rsp_beat.frame_length   = len;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= TIMEOUT_RESET;
         seen_ff    <= '0;
         done_ff    <= 1'b0;
         running_ff <= 1'b0;
         elapsed_ff <= '0;
         stored_ff  <= '0;
      end else begin
         limit_ff   <= limit_in;
         seen_ff    <= seen_in;
         done_ff    <= done_in;
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
         stored_ff  <= stored_in;
      end
   end

   `ASSERT_IMPLIES(a_done_all_seen, clock, reset, done_ff, seen_ff == 4'hF, "complete without all messages")
   `ASSERT_IMPLIES(a_stop_on_tick, clock, reset, $fell(running_ff), $past(go && mid_entry.op == CMD_TICK), "capture stopped outside a tick")
   `ASSERT_IMPLIES(a_timeout_form, clock, reset, rsp_push && rsp_beat.event_kind == EVENT_TIMEOUT, rsp_beat.message_number == MSG_NONE && !rsp_beat.active, "malformed timeout beat")

endmodule

`default_nettype wire
